// ----- rtl/idm_vehicle_speed_update_core_assert.svh -----
// assertion macros for the idm vehicle speed update core
// used by the port checker; needs nothing else
`ifndef IDM_VEHICLE_SPEED_UPDATE_CORE_ASSERT_SVH
`define IDM_VEHICLE_SPEED_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define IDMV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idmv check failed");

// next-cycle implication, reset masks the check
`define IDMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idmv check failed");

`endif

// ----- rtl/idmv_pkg.sv -----
// shared types, constants and register codes for the idm speed update core
// no dependencies
package idmv_pkg;

  // storage depths
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 128;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP_TIME     = 3'd0;
  localparam logic [2:0] CFG_MAX_ACCEL     = 3'd1;
  localparam logic [2:0] CFG_COMFORT_DECEL = 3'd2;
  localparam logic [2:0] CFG_MIN_GAP       = 3'd3;
  localparam logic [2:0] CFG_HEADWAY       = 3'd4;

  // configuration reset values
  localparam logic [15:0] RST_STEP_TIME     = 16'd3277;
  localparam logic [9:0]  RST_MAX_ACCEL     = 10'd384;
  localparam logic [9:0]  RST_COMFORT_DECEL = 10'd512;
  localparam logic [11:0] RST_MIN_GAP       = 12'd512;
  localparam logic [10:0] RST_HEADWAY       = 11'd384;

  // model constants
  localparam logic [19:0] GAP_FLOOR  = 20'd102;
  localparam logic [15:0] V0_FLOOR   = 16'd512;
  localparam logic [22:0] RATIO_CAP  = 23'h400000;
  localparam logic [15:0] SLOW_SPEED = 16'd128;
  localparam logic [19:0] WAIT_MAX   = 20'hFFFFF;
  localparam logic signed [11:0] ACC_MIN = -12'sd1664;

  typedef struct packed {
    logic [15:0] step_time;
    logic [9:0]  max_accel;
    logic [9:0]  comfort_decel;
    logic [11:0] min_gap;
    logic [10:0] headway;
  } idmv_cfg_t;

  typedef struct packed {
    logic       ready;
    logic [9:0] root;
  } idmv_root_t;

  typedef struct packed {
    logic [15:0] v;
    logic [15:0] v0;
    logic [19:0] sgap;
    logic [15:0] lead;
    logic [19:0] waited;
  } idmv_item_t;

  typedef struct packed {
    logic [15:0]        new_speed;
    logic signed [11:0] acc;
    logic [19:0]        new_waited;
  } idmv_result_t;

endpackage

// ----- rtl/idmv_front.sv -----
// front end: accepts vehicles, applies junction stop and floors, queues them
// depends on idmv_pkg
module idmv_front import idmv_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] speed,
  input  logic [15:0] desired_speed,
  input  logic [19:0] gap,
  input  logic [15:0] leader_speed,
  input  logic        blocked,
  input  logic [19:0] stop_distance,
  input  logic [19:0] waited,
  output logic        q_valid,
  output idmv_item_t  q_item,
  input  logic        q_take
);

  localparam int PW = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int CW = $clog2(MID_DEPTH + 1);

  idmv_item_t     fifo_mem [MID_DEPTH];
  idmv_item_t     cls;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           wr_en;
  logic           stop_hit;
  logic [19:0]    gap_eff;

  // classify: junction stop replaces the leader, floors on v0 and gap
  always_comb begin
    stop_hit   = blocked && (stop_distance < gap);
    gap_eff    = stop_hit ? stop_distance : gap;
    cls.v      = speed;
    cls.v0     = (desired_speed < V0_FLOOR) ? V0_FLOOR : desired_speed;
    cls.sgap   = (gap_eff > GAP_FLOOR) ? gap_eff : GAP_FLOOR;
    cls.lead   = stop_hit ? 16'd0 : leader_speed;
    cls.waited = waited;
  end

  assign full    = (count == CW'(MID_DEPTH));
  assign wr_en   = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = fifo_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !q_take) begin
      count_next = count + 1'b1;
    end else if (!wr_en && q_take) begin
      count_next = count - 1'b1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(MID_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_take) begin
        rd_ptr <= (rd_ptr == PW'(MID_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wr_ptr] <= cls;
    end
  end

endmodule

// ----- rtl/idmv_sqrt.sv -----
// iterative integer square root of max_accel times comfort_decel
// depends on idmv_pkg; one result bit per cycle, restarts on start
module idmv_sqrt import idmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  idmv_cfg_t  cfg,
  output idmv_root_t root_st
);

  typedef enum logic [1:0] {SQ_LOAD, SQ_RUN, SQ_IDLE} sq_state_t;

  sq_state_t   state;
  logic [19:0] x;
  logic [19:0] res;
  logic [19:0] bitv;
  logic [20:0] trial;
  logic [9:0]  a_eff;
  logic [9:0]  b_eff;

  assign a_eff = (cfg.max_accel == '0) ? 10'd1 : cfg.max_accel;
  assign b_eff = (cfg.comfort_decel == '0) ? 10'd1 : cfg.comfort_decel;
  assign trial = {1'b0, res} + {1'b0, bitv};

  // digit-by-digit root, bit walks from 2^18 down to 1
  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= SQ_LOAD;
    end else begin
      case (state)
        SQ_LOAD: begin
          x     <= a_eff * b_eff;
          res   <= '0;
          bitv  <= 20'h40000;
          state <= SQ_RUN;
        end
        SQ_RUN: begin
          if ({1'b0, x} >= trial) begin
            x   <= x - trial[19:0];
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= SQ_IDLE;
          end
        end
        SQ_IDLE: begin
          state <= SQ_IDLE;
        end
        default: begin
          state <= SQ_LOAD;
        end
      endcase
    end
  end

  assign root_st.ready = (state == SQ_IDLE);
  assign root_st.root  = res[9:0];

endmodule

// ----- rtl/idmv_back.sv -----
// back end: free-running pipeline for desired gap, ratios, acceleration, speed
// depends on idmv_pkg; fed from the front queue, drains into the output queue
module idmv_back import idmv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  idmv_cfg_t    cfg,
  input  idmv_root_t   root_st,
  input  logic         q_valid,
  input  idmv_item_t   q_item,
  output logic         q_take,
  input  logic         room,
  output logic         issue,
  output logic         res_valid,
  output idmv_result_t res
);

  localparam int RD_BITS = 34;
  localparam int QD_BITS = 23;
  localparam logic [34:0] T_SAT = 35'h4_0000_0000;
  localparam logic signed [45:0] S_FLOOR = -46'sd109051905;

  typedef struct packed {
    logic        vld;
    idmv_item_t  it;
    logic [26:0] vh;
    logic        neg;
    logic        sat;
    logic [39:0] rem;
    logic [33:0] quo;
  } rd_st_t;

  typedef struct packed {
    logic        vld;
    idmv_item_t  it;
    logic        rcap;
    logic [44:0] rrem;
    logic [22:0] rquo;
    logic [31:0] qrem;
    logic [22:0] qquo;
  } qd_st_t;

  logic [9:0] a_eff;
  assign a_eff = (cfg.max_accel == '0) ? 10'd1 : cfg.max_accel;

  assign issue  = q_valid && root_st.ready && room;
  assign q_take = issue;

  // issue register
  logic       vld0;
  idmv_item_t it0;
  always_ff @(posedge clk) begin
    it0 <= q_item;
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= issue;
    end
  end

  // speed times relative speed
  logic               vld1;
  idmv_item_t         it1;
  logic signed [33:0] pd1;
  always_ff @(posedge clk) begin
    it1 <= it0;
    pd1 <= $signed({1'b0, it0.v}) * ($signed({1'b0, it0.v}) - $signed({1'b0, it0.lead}));
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= vld0;
    end
  end

  // headway term, magnitude and saturation test for the root division
  rd_st_t      rd [RD_BITS+1];
  logic [33:0] mag1;
  logic [39:0] rem1;
  always_comb begin
    mag1 = pd1[33] ? 34'(-pd1) : 34'(pd1);
    rem1 = {mag1[32:0], 7'd0};
  end

  always_ff @(posedge clk) begin
    rd[0].vld <= rst ? 1'b0 : vld1;
    rd[0].it  <= it1;
    rd[0].vh  <= it1.v * cfg.headway;
    rd[0].neg <= pd1[33];
    rd[0].sat <= {4'd0, rem1} >= {root_st.root, 34'd0};
    rd[0].rem <= rem1;
    rd[0].quo <= '0;
  end

  // restoring division by the root, one quotient bit per stage
  for (genvar k = 0; k < RD_BITS; k++) begin : g_rdiv
    localparam int B = RD_BITS - 1 - k;
    logic [43:0] dsh;
    logic        ge;
    rd_st_t      nx;
    always_comb begin
      dsh = 44'(root_st.root) << B;
      ge  = {4'd0, rd[k].rem} >= dsh;
      nx  = rd[k];
      if (ge) begin
        nx.rem    = rd[k].rem - dsh[39:0];
        nx.quo[B] = 1'b1;
      end
      if (rst) begin
        nx.vld = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      rd[k+1] <= nx;
    end
  end

  // signed velocity term joins the headway term, clamped at zero
  logic        vld3;
  idmv_item_t  it3;
  logic [35:0] inner3;
  logic [34:0] t2;
  logic [36:0] sum2;
  always_comb begin
    t2   = rd[RD_BITS].sat ? T_SAT : {1'b0, rd[RD_BITS].quo};
    sum2 = rd[RD_BITS].neg ? ({10'd0, rd[RD_BITS].vh} - {2'd0, t2})
                           : ({10'd0, rd[RD_BITS].vh} + {2'd0, t2});
  end
  always_ff @(posedge clk) begin
    it3    <= rd[RD_BITS].it;
    inner3 <= sum2[36] ? 36'd0 : sum2[35:0];
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= rd[RD_BITS].vld;
    end
  end

  // desired gap
  logic        vld4;
  idmv_item_t  it4;
  logic [36:0] sstar4;
  always_ff @(posedge clk) begin
    it4    <= it3;
    sstar4 <= {17'd0, cfg.min_gap, 8'd0} + {1'b0, inner3};
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  // set up both ratio divisions, flag a gap ratio past the cap
  qd_st_t      qd [QD_BITS+1];
  logic [44:0] dvd4;
  assign dvd4 = {sstar4, 8'd0};
  always_ff @(posedge clk) begin
    qd[0].vld  <= rst ? 1'b0 : vld4;
    qd[0].it   <= it4;
    qd[0].rcap <= dvd4 >= {2'd0, it4.sgap, 23'd0};
    qd[0].rrem <= dvd4;
    qd[0].rquo <= '0;
    qd[0].qrem <= {it4.v, 16'd0};
    qd[0].qquo <= '0;
  end

  // gap ratio and speed ratio divisions side by side
  for (genvar k = 0; k < QD_BITS; k++) begin : g_qdiv
    localparam int B = QD_BITS - 1 - k;
    logic [44:0] rdsh;
    logic [38:0] qdsh;
    qd_st_t      nx;
    always_comb begin
      rdsh = 45'(qd[k].it.sgap) << B;
      qdsh = 39'(qd[k].it.v0) << B;
      nx   = qd[k];
      if (qd[k].rrem >= rdsh) begin
        nx.rrem    = qd[k].rrem - rdsh;
        nx.rquo[B] = 1'b1;
      end
      if ({7'd0, qd[k].qrem} >= qdsh) begin
        nx.qrem    = qd[k].qrem - qdsh[31:0];
        nx.qquo[B] = 1'b1;
      end
      if (rst) begin
        nx.vld = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      qd[k+1] <= nx;
    end
  end

  // ratio caps
  logic        vld6;
  idmv_item_t  it6;
  logic [22:0] rc6;
  logic [22:0] qc6;
  always_ff @(posedge clk) begin
    it6 <= qd[QD_BITS].it;
    rc6 <= (qd[QD_BITS].rcap || (qd[QD_BITS].rquo > RATIO_CAP)) ? RATIO_CAP
                                                                 : qd[QD_BITS].rquo;
    qc6 <= (qd[QD_BITS].qquo > RATIO_CAP) ? RATIO_CAP : qd[QD_BITS].qquo;
    if (rst) begin
      vld6 <= 1'b0;
    end else begin
      vld6 <= qd[QD_BITS].vld;
    end
  end

  // squares of both ratios
  logic        vld7;
  idmv_item_t  it7;
  logic [29:0] r2_7;
  logic [29:0] q2_7;
  logic [45:0] rsq6;
  logic [45:0] qsq6;
  assign rsq6 = rc6 * rc6;
  assign qsq6 = qc6 * qc6;
  always_ff @(posedge clk) begin
    it7  <= it6;
    r2_7 <= rsq6[45:16];
    q2_7 <= qsq6[45:16];
    if (rst) begin
      vld7 <= 1'b0;
    end else begin
      vld7 <= vld6;
    end
  end

  // fourth power of the speed ratio
  logic        vld8;
  idmv_item_t  it8;
  logic [29:0] r2_8;
  logic [43:0] q4_8;
  logic [59:0] q4sq7;
  assign q4sq7 = q2_7 * q2_7;
  always_ff @(posedge clk) begin
    it8  <= it7;
    r2_8 <= r2_7;
    q4_8 <= q4sq7[59:16];
    if (rst) begin
      vld8 <= 1'b0;
    end else begin
      vld8 <= vld7;
    end
  end

  // one minus both terms, floored where the clamp decides anyway
  logic               vld9;
  idmv_item_t         it9;
  logic signed [28:0] s9;
  logic signed [45:0] s8;
  assign s8 = $signed(46'd65536) - $signed({2'd0, q4_8}) - $signed({16'd0, r2_8});
  always_ff @(posedge clk) begin
    it9 <= it8;
    s9  <= (s8 < S_FLOOR) ? 29'(S_FLOOR) : s8[28:0];
    if (rst) begin
      vld9 <= 1'b0;
    end else begin
      vld9 <= vld8;
    end
  end

  // scale by maximum acceleration
  logic               vld10;
  idmv_item_t         it10;
  logic signed [39:0] p10;
  always_ff @(posedge clk) begin
    it10 <= it9;
    p10  <= $signed({1'b0, a_eff}) * s9;
    if (rst) begin
      vld10 <= 1'b0;
    end else begin
      vld10 <= vld9;
    end
  end

  // floor to q4.8 and clamp
  logic               vld11;
  idmv_item_t         it11;
  logic signed [11:0] acc11;
  logic signed [23:0] pf10;
  assign pf10 = 24'(p10 >>> 16);
  always_ff @(posedge clk) begin
    it11 <= it10;
    if (pf10 < 24'(ACC_MIN)) begin
      acc11 <= ACC_MIN;
    end else if (pf10 > $signed({14'd0, a_eff})) begin
      acc11 <= $signed({2'd0, a_eff});
    end else begin
      acc11 <= pf10[11:0];
    end
    if (rst) begin
      vld11 <= 1'b0;
    end else begin
      vld11 <= vld10;
    end
  end

  // speed change over one step
  logic               vld12;
  idmv_item_t         it12;
  logic signed [11:0] acc12;
  logic signed [28:0] m12;
  always_ff @(posedge clk) begin
    it12  <= it11;
    acc12 <= acc11;
    m12   <= acc11 * $signed({1'b0, cfg.step_time});
    if (rst) begin
      vld12 <= 1'b0;
    end else begin
      vld12 <= vld11;
    end
  end

  // new speed, floored and saturated
  logic               vld13;
  idmv_item_t         it13;
  logic signed [11:0] acc13;
  logic [15:0]        ns13;
  logic signed [33:0] nsum12;
  logic signed [17:0] nf12;
  assign nsum12 = $signed({2'd0, it12.v, 16'd0}) + 34'(m12);
  assign nf12   = 18'(nsum12 >>> 16);
  always_ff @(posedge clk) begin
    it13  <= it12;
    acc13 <= acc12;
    if (nf12 < 0) begin
      ns13 <= 16'd0;
    end else if (nf12 > $signed(18'd65535)) begin
      ns13 <= 16'hFFFF;
    end else begin
      ns13 <= nf12[15:0];
    end
    if (rst) begin
      vld13 <= 1'b0;
    end else begin
      vld13 <= vld12;
    end
  end

  // waiting time: grows while nearly stopped, decays otherwise
  logic [16:0] inc_sum;
  logic [16:0] dec_sum;
  logic [8:0]  inc13;
  logic [7:0]  dec13;
  logic [20:0] wup13;
  always_comb begin
    inc_sum = {1'b0, cfg.step_time} + 17'd128;
    dec_sum = {1'b0, cfg.step_time} + 17'd256;
    inc13   = inc_sum[16:8];
    dec13   = dec_sum[16:9];
    wup13   = {1'b0, it13.waited} + {12'd0, inc13};
  end

  always_ff @(posedge clk) begin
    res.new_speed <= ns13;
    res.acc       <= acc13;
    if (ns13 < SLOW_SPEED) begin
      res.new_waited <= wup13[20] ? WAIT_MAX : wup13[19:0];
    end else begin
      res.new_waited <= (it13.waited < {12'd0, dec13}) ? 20'd0
                                                      : it13.waited - {12'd0, dec13};
    end
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= vld13;
    end
  end

endmodule

// ----- rtl/idmv_outq.sv -----
// output queue with credit count covering results still in the pipeline
// depends on idmv_pkg; memory with registered read into the result register
module idmv_outq import idmv_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         reserve,
  output logic         room,
  input  logic         wr_valid,
  input  idmv_result_t wr_data,
  output logic         empty,
  input  logic         pop,
  output idmv_result_t rd_data
);

  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  idmv_result_t  mem [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] credits;
  logic [CW-1:0] mcount;
  logic          ov;
  logic          pop_acc;
  logic          load;

  assign pop_acc = pop && ov;
  assign load    = (mcount != '0) && (!ov || pop_acc);
  assign empty   = !ov;
  assign room    = (credits < CW'(OUT_DEPTH));

  // credits, fill count, pointers, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
      mcount  <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      ov      <= 1'b0;
    end else begin
      credits <= credits + CW'(reserve) - CW'(pop_acc);
      mcount  <= mcount + CW'(wr_valid) - CW'(load);
      if (wr_valid) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        ov     <= 1'b1;
      end else if (pop_acc) begin
        ov <= 1'b0;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

// ----- rtl/idm_vehicle_speed_update_core.sv -----
// idm vehicle speed update core: one vehicle accepted per cycle unless full is set,
// one result each; results pass the 34-step root division and the 23-step ratio
// divisions in the back end before they show on the result ports
// after reset and after a write of max_accel or comfort_decel the root unit recomputes
// the root; pushed items wait in the front queue until it is done
// reset clears all queues and loads the register reset values
module idm_vehicle_speed_update_core import idmv_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        speed,
  input  logic [15:0]        desired_speed,
  input  logic [19:0]        gap,
  input  logic [15:0]        leader_speed,
  input  logic               blocked,
  input  logic [19:0]        stop_distance,
  input  logic [19:0]        waited,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        new_speed,
  output logic signed [11:0] acceleration,
  output logic [19:0]        new_waited,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  idmv_cfg_t    cfg;
  idmv_root_t   root_st;
  idmv_item_t   q_item;
  idmv_result_t res;
  idmv_result_t out_res;
  logic         q_valid;
  logic         q_take;
  logic         room;
  logic         issue;
  logic         res_valid;
  logic         root_start;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time     <= RST_STEP_TIME;
      cfg.max_accel     <= RST_MAX_ACCEL;
      cfg.comfort_decel <= RST_COMFORT_DECEL;
      cfg.min_gap       <= RST_MIN_GAP;
      cfg.headway       <= RST_HEADWAY;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_STEP_TIME:     cfg.step_time     <= cfg_data;
        CFG_MAX_ACCEL:     cfg.max_accel     <= cfg_data[9:0];
        CFG_COMFORT_DECEL: cfg.comfort_decel <= cfg_data[9:0];
        CFG_MIN_GAP:       cfg.min_gap       <= cfg_data[11:0];
        CFG_HEADWAY:       cfg.headway       <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // root must be recomputed when either factor changes
  assign root_start = cfg_wr &&
                      ((cfg_index == CFG_MAX_ACCEL) || (cfg_index == CFG_COMFORT_DECEL));

  idmv_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .speed         (speed),
    .desired_speed (desired_speed),
    .gap           (gap),
    .leader_speed  (leader_speed),
    .blocked       (blocked),
    .stop_distance (stop_distance),
    .waited        (waited),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take)
  );

  idmv_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .cfg     (cfg),
    .root_st (root_st)
  );

  idmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .root_st   (root_st),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .room      (room),
    .issue     (issue),
    .res_valid (res_valid),
    .res       (res)
  );

  idmv_outq #(.OUT_DEPTH(OUT_DEPTH)) u_outq (
    .clk      (clk),
    .rst      (rst),
    .reserve  (issue),
    .room     (room),
    .wr_valid (res_valid),
    .wr_data  (res),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (out_res)
  );

  assign new_speed    = out_res.new_speed;
  assign acceleration = out_res.acc;
  assign new_waited   = out_res.new_waited;

endmodule

// ----- rtl/idmv_checker.sv -----
// port-level checker for the idm vehicle speed update core, bound to the top
// depends on idm_vehicle_speed_update_core_assert.svh
`include "idm_vehicle_speed_update_core_assert.svh"

module idmv_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [15:0]        new_speed,
  input logic signed [11:0] acceleration,
  input logic [19:0]        new_waited
);

  // no result shows right after reset
  `IDMV_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty)

  // a waiting result is not withdrawn
  `IDMV_ASSERT_NEXT(a_result_stays, clk, rst, !empty && !pop, !empty)

  // a result never goes below the hard deceleration limit
  `IDMV_ASSERT_NOW(a_acc_floor, clk, rst, !empty, acceleration >= -12'sd1664)

  // a waiting result holds its value
  `IDMV_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop,
    $stable(new_speed) && $stable(acceleration) && $stable(new_waited))

endmodule

bind idm_vehicle_speed_update_core idmv_checker u_chk (.*);
